@@ rtl/core/owtr_pkg.sv @@
// Shared types and register map for the 1-Wire temperature read master.
package owtr_pkg;

    localparam int CFG_W    = 10;
    localparam int NUM_REGS = 7;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WRITE_ONE_LOW = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SLOT          = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_READ_LOW      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_READ_TAIL     = 3'd6;

    localparam logic [CFG_W-1:0] RST_RESET_LOW     = 10'd480;
    localparam logic [CFG_W-1:0] RST_PRESENCE_WAIT = 10'd80;
    localparam logic [CFG_W-1:0] RST_RESET_TAIL    = 10'd400;
    localparam logic [CFG_W-1:0] RST_WRITE_ONE_LOW = 10'd1;
    localparam logic [CFG_W-1:0] RST_SLOT          = 10'd50;
    localparam logic [CFG_W-1:0] RST_READ_LOW      = 10'd2;
    localparam logic [CFG_W-1:0] RST_READ_TAIL     = 10'd60;

    // Command codes carried in the cmd field of an input transaction.
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_RESET = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_READ  = 3'd3;
    localparam logic [2:0] CMD_TEMP  = 3'd4;

    // ROM and function commands issued by the temperature sequence.
    localparam logic [7:0] ROM_SKIP        = 8'hCC;
    localparam logic [7:0] FN_CONVERT      = 8'h44;
    localparam logic [7:0] FN_READ_SCRATCH = 8'hBE;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] tx_byte;
        logic       line_level;
    } in_item_t;

    typedef struct packed {
        logic               line_low;
        logic               busy_res;
        logic               done_res;
        logic               presence;
        logic [7:0]         rx_byte;
        logic signed [15:0] temperature;
    } out_item_t;

endpackage

@@ rtl/core/one_wire_master_temp_read.sv @@
// Top level of the 1-Wire master with built-in temperature read sequence.
//
//   cmd channel (cmd_valid / cmd_stall / cmd_item) carries one transaction per
//   microsecond tick (cmd 0, with the sampled bus level) or a command: reset
//   with presence detect, write byte, read byte, or full temperature read.
//   res channel (res_valid / res_stall / res_item) returns exactly one
//   transaction per accepted cmd transaction: bus drive, busy, done, presence,
//   last read byte and last temperature in 1/16 degree units.
// Path: the input register holds an accepted transaction, then the sequencer
//   updates its state and loads the result register, where res_valid rises.
// Throughput: one transaction per cycle while the result is not stalled;
//   res_item is the state after handling the transaction.
// Stall: a stalled result holds in the result register while one more cmd
//   transaction waits in the input register; cmd_stall rises only then.
// Reset: timing registers return to their defaults, the sequencer goes idle,
//   all captured values clear and both channels empty.
// Configuration: write cfg_data to register cfg_index with cfg_we while no
//   transaction is in flight; a running phase uses the new value next tick.
module one_wire_master_temp_read
    import owtr_pkg::*;
#(
    parameter int TIMER_BITS = 10
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  in_item_t             cmd_item,
    output logic                 res_valid,
    input  logic                 res_stall,
    output out_item_t            res_item,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic                                hold_valid_reg;
    in_item_t                            hold_item_reg;
    logic                                res_valid_reg;
    out_item_t                           res_item_reg;
    out_item_t                           engine_result;
    logic                                advance;
    logic [NUM_REGS-1:0][TIMER_BITS-1:0] dur;

    // Process the held transaction whenever the result slot is free or draining.
    assign advance   = hold_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = hold_valid_reg && !advance;

    owtr_cfg_regs #(
        .TIMER_BITS (TIMER_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dur       (dur)
    );

    owtr_engine #(
        .TIMER_BITS (TIMER_BITS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .item   (hold_item_reg),
        .dur    (dur),
        .result (engine_result)
    );

    // Input register: load on acceptance, drop once processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (cmd_valid && !cmd_stall)
            hold_valid_reg <= 1'b1;
        else if (advance)
            hold_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
            hold_item_reg <= cmd_item;
    end

    // Result register: hold while stalled, advance when the sequencer fires.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_item_reg <= engine_result;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // A completing transaction never reports busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_item.done_res && res_item.busy_res))
        else $error("done and busy reported together");

    // The bus is only driven low while a command runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_item.line_low) |-> res_item.busy_res)
        else $error("bus driven low while idle");

    // Input backpressure only comes from a stalled, occupied result slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (res_valid && res_stall && hold_valid_reg))
        else $error("cmd stalled without a stalled result");

    // Every processed transaction shows up as a result next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid)
        else $error("processed transaction lost");

endmodule

@@ rtl/core/owtr_cfg_regs.sv @@
// Timing register file with clamping of each duration to the timer range.
module owtr_cfg_regs
    import owtr_pkg::*;
#(
    parameter int TIMER_BITS = 10
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_we,
    input  logic [REG_IDX_W-1:0]                     cfg_index,
    input  logic [CFG_W-1:0]                         cfg_data,
    output logic [NUM_REGS-1:0][TIMER_BITS-1:0]      dur
);

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [CMP_W-1:0] TMAX = CMP_W'((64'd1 << TIMER_BITS) - 64'd1);

    logic [NUM_REGS-1:0][CFG_W-1:0] cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_RESET_LOW]     <= RST_RESET_LOW;
            cfg_reg[REG_PRESENCE_WAIT] <= RST_PRESENCE_WAIT;
            cfg_reg[REG_RESET_TAIL]    <= RST_RESET_TAIL;
            cfg_reg[REG_WRITE_ONE_LOW] <= RST_WRITE_ONE_LOW;
            cfg_reg[REG_SLOT]          <= RST_SLOT;
            cfg_reg[REG_READ_LOW]      <= RST_READ_LOW;
            cfg_reg[REG_READ_TAIL]     <= RST_READ_TAIL;
        end
        else if (cfg_we && (cfg_index < REG_IDX_W'(NUM_REGS)))
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // Zero acts as one tick; cap at the largest count the timer holds.
    always_comb
    begin
        logic [CMP_W-1:0] v;
        logic [CMP_W-1:0] d;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            v = CMP_W'(cfg_reg[i]);
            if (v == '0)
                d = CMP_W'(1);
            else if (v > TMAX)
                d = TMAX;
            else
                d = v;
            dur[i] = d[TIMER_BITS-1:0];
        end
    end

endmodule

@@ rtl/core/owtr_engine.sv @@
// Bus phase sequencer: one item per enabled cycle, result from next state.
module owtr_engine
    import owtr_pkg::*;
#(
    parameter int TIMER_BITS = 10
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  in_item_t                            item,
    input  logic [NUM_REGS-1:0][TIMER_BITS-1:0] dur,
    output out_item_t                           result
);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_RST_LOW  = 4'd1;
    localparam logic [3:0] PH_RST_WAIT = 4'd2;
    localparam logic [3:0] PH_RST_TAIL = 4'd3;
    localparam logic [3:0] PH_W1_LOW   = 4'd4;
    localparam logic [3:0] PH_W1_REL   = 4'd5;
    localparam logic [3:0] PH_W0_LOW   = 4'd6;
    localparam logic [3:0] PH_W0_REL   = 4'd7;
    localparam logic [3:0] PH_RD_LOW   = 4'd8;
    localparam logic [3:0] PH_RD_SAMP  = 4'd9;
    localparam logic [3:0] PH_RD_TAIL  = 4'd10;

    logic [3:0]            phase_reg, phase_next;
    logic [TIMER_BITS-1:0] tick_reg, tick_next;
    logic [2:0]            bit_reg, bit_next;
    logic [7:0]            shift_reg, shift_next;
    logic [3:0]            step_reg, step_next;
    logic [2:0]            active_reg, active_next;
    logic [7:0]            low_reg, low_next;
    logic                  pres_reg, pres_next;
    logic [7:0]            rx_reg, rx_next;
    logic [15:0]           temp_reg, temp_next;

    function automatic logic [3:0] write_phase(input logic [7:0] b, input logic [2:0] idx);
        return b[idx] ? PH_W1_LOW : PH_W0_LOW;
    endfunction

    always_comb
    begin
        logic [TIMER_BITS-1:0] d;
        logic                  timed;
        logic [TIMER_BITS-1:0] tick_inc;
        logic                  bit_done;
        logic                  reading;
        logic                  unit_done;
        logic [3:0]            seq;
        logic                  done;

        phase_next  = phase_reg;
        tick_next   = tick_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        step_next   = step_reg;
        active_next = active_reg;
        low_next    = low_reg;
        pres_next   = pres_reg;
        rx_next     = rx_reg;
        temp_next   = temp_reg;
        bit_done    = 1'b0;
        reading     = 1'b0;
        unit_done   = 1'b0;
        done        = 1'b0;
        seq         = step_reg + 4'd1;
        tick_inc    = tick_reg + TIMER_BITS'(1);
        timed       = 1'b1;

        unique case (phase_reg) inside
            PH_RST_LOW:             d = dur[REG_RESET_LOW];
            PH_RST_WAIT:            d = dur[REG_PRESENCE_WAIT];
            PH_RST_TAIL:            d = dur[REG_RESET_TAIL];
            PH_W1_LOW:              d = dur[REG_WRITE_ONE_LOW];
            PH_W1_REL, PH_W0_LOW:   d = dur[REG_SLOT];
            PH_RD_LOW:              d = dur[REG_READ_LOW];
            PH_RD_TAIL:             d = dur[REG_READ_TAIL];
            PH_W0_REL, PH_RD_SAMP:  d = TIMER_BITS'(1);
            default:
            begin
                d     = TIMER_BITS'(1);
                timed = 1'b0;
            end
        endcase

        if (item.cmd == CMD_TICK)
        begin
            if (timed)
            begin
                tick_next = tick_inc;
                if (tick_inc >= d)
                begin
                    tick_next = '0;
                    unique case (phase_reg) inside
                        PH_RST_LOW:  phase_next = PH_RST_WAIT;
                        PH_RST_WAIT:
                        begin
                            pres_next  = ~item.line_level;
                            phase_next = PH_RST_TAIL;
                        end
                        PH_RST_TAIL: unit_done = 1'b1;
                        PH_W1_LOW:   phase_next = PH_W1_REL;
                        PH_W0_LOW:   phase_next = PH_W0_REL;
                        PH_W1_REL, PH_W0_REL: bit_done = 1'b1;
                        PH_RD_LOW:   phase_next = PH_RD_SAMP;
                        PH_RD_SAMP:
                        begin
                            if (item.line_level)
                                shift_next[bit_reg] = 1'b1;
                            phase_next = PH_RD_TAIL;
                        end
                        PH_RD_TAIL:
                        begin
                            bit_done = 1'b1;
                            reading  = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
        end
        else if (phase_reg == PH_IDLE && item.cmd <= CMD_TEMP)
        begin
            active_next = item.cmd;
            step_next   = '0;
            tick_next   = '0;
            bit_next    = '0;
            if (item.cmd == CMD_WRITE)
            begin
                shift_next = item.tx_byte;
                phase_next = write_phase(item.tx_byte, 3'd0);
            end
            else if (item.cmd == CMD_READ)
            begin
                shift_next = '0;
                phase_next = PH_RD_LOW;
            end
            else
            begin
                phase_next = PH_RST_LOW;
            end
        end

        // Advance to the next bit or close out the byte.
        if (bit_done)
        begin
            if (bit_reg == 3'd7)
                unit_done = 1'b1;
            else
            begin
                bit_next   = bit_reg + 3'd1;
                phase_next = reading ? PH_RD_LOW : write_phase(shift_reg, bit_reg + 3'd1);
            end
        end

        // Step the temperature sequence or finish the command.
        if (unit_done)
        begin
            done = 1'b1;
            if (active_reg == CMD_TEMP)
            begin
                if (step_reg == 4'd6)
                    low_next = shift_reg;
                if (step_reg == 4'd7)
                    temp_next = {shift_reg, low_reg};
                step_next = seq;
                done      = 1'b0;
                bit_next  = '0;
                case (seq) inside
                    4'd1, 4'd4:
                    begin
                        shift_next = ROM_SKIP;
                        phase_next = write_phase(ROM_SKIP, 3'd0);
                    end
                    4'd2:
                    begin
                        shift_next = FN_CONVERT;
                        phase_next = write_phase(FN_CONVERT, 3'd0);
                    end
                    4'd3:
                        phase_next = PH_RST_LOW;
                    4'd5:
                    begin
                        shift_next = FN_READ_SCRATCH;
                        phase_next = write_phase(FN_READ_SCRATCH, 3'd0);
                    end
                    4'd6, 4'd7:
                    begin
                        shift_next = '0;
                        phase_next = PH_RD_LOW;
                    end
                    default:
                        done = 1'b1;
                endcase
            end
            else if (active_reg == CMD_READ)
            begin
                rx_next = shift_reg;
            end
            if (done)
            begin
                phase_next  = PH_IDLE;
                step_next   = '0;
                active_next = '0;
            end
        end

        result.line_low    = (phase_next == PH_RST_LOW) || (phase_next == PH_W1_LOW) ||
                             (phase_next == PH_W0_LOW) || (phase_next == PH_RD_LOW);
        result.busy_res    = (phase_next != PH_IDLE);
        result.done_res    = done;
        result.presence    = pres_next;
        result.rx_byte     = rx_next;
        result.temperature = $signed(temp_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            tick_reg   <= '0;
            bit_reg    <= '0;
            shift_reg  <= '0;
            step_reg   <= '0;
            active_reg <= '0;
            low_reg    <= '0;
            pres_reg   <= 1'b0;
            rx_reg     <= '0;
            temp_reg   <= '0;
        end
        else if (en)
        begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            bit_reg    <= bit_next;
            shift_reg  <= shift_next;
            step_reg   <= step_next;
            active_reg <= active_next;
            low_reg    <= low_next;
            pres_reg   <= pres_next;
            rx_reg     <= rx_next;
            temp_reg   <= temp_next;
        end
    end

endmodule
